/* rtl/core/simpson_rule_integrator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the integrator RTL.
// Both macros expect signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef SIMPSON_RULE_INTEGRATOR_MACROS_SVH
`define SIMPSON_RULE_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sri: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SRI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sri: next-cycle check failed");

`endif

/* rtl/core/sri_pkg.sv */
// ----------------------------------------------------------------------------
// sri_pkg
// Widths and the queue entry type shared by the integrator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sri_pkg;

  // Field widths of the channels.
  localparam int SRI_POS_W  = 24;
  localparam int SRI_VAL_W  = 24;
  localparam int SRI_RES_W  = 64;

  // Operand widths: a position difference and a weighted value sum.
  localparam int SRI_DX_W   = SRI_POS_W + 1;
  localparam int SRI_WT_W   = SRI_VAL_W + 3;
  localparam int SRI_PROD_W = SRI_DX_W + SRI_WT_W;

  // Default depth of the queue between front and back.
  localparam int SRI_FIFO_DEPTH = 4;

  // One unit of work for the back end.
  typedef struct packed {
    logic                       grp;  // add a Simpson group term
    logic                       trp;  // final trapezoid over the last interval
    logic                       lst;  // close the run and emit a result
    logic signed [SRI_DX_W-1:0] dx;
    logic signed [SRI_WT_W-1:0] wt;
  } sri_op_t;

endpackage

`default_nettype wire

/* rtl/core/sri_in_if.sv */
// ----------------------------------------------------------------------------
// sri_in_if
// Sample channel: position, function value and end-of-run mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface sri_in_if
  import sri_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic signed [SRI_POS_W-1:0] x_pos;
  logic signed [SRI_VAL_W-1:0] sample;
  logic                        last;

  modport source (output valid, output x_pos, output sample, output last, input ready);
  modport sink   (input valid, input x_pos, input sample, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/sri_out_if.sv */
// ----------------------------------------------------------------------------
// sri_out_if
// Result channel: integral estimate and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sri_out_if
  import sri_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic signed [SRI_RES_W-1:0] integral;
  logic                        overflow;

  modport source (output valid, output integral, output overflow, input ready);
  modport sink   (input valid, input integral, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/simpson_rule_integrator.sv */
// ----------------------------------------------------------------------------
// simpson_rule_integrator
// Streaming composite Simpson integrator over unevenly spaced samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the "in" channel as signed Q12.12 position and value;
//   last marks the final sample of a run. A run of N samples yields exactly
//   one transfer on the "out" channel: the Q40.24 integral, saturated to 64
//   bits, and an overflow flag set if any saturation occurred in the run.
//   Samples other than the last produce no result.
//   Throughput is one sample per cycle while the queue is not full. A result
//   is first offered once the last sample has passed through the queue into
//   the multiplier, the accumulator, the rounding-bias register, the
//   divide-by-three pipeline (eight quotient bits per stage), the sign
//   restore register and the final saturating add into the output register.
//   When the receiver stalls, the whole back pipeline holds; the queue keeps
//   taking samples until it is full, then in.ready drops.
//   Reset clears the run state, the queue and all pipeline valids.
// ----------------------------------------------------------------------------
`default_nettype none

module simpson_rule_integrator
  import sri_pkg::*;
#(
  parameter int QUEUE_DEPTH = SRI_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  sri_in_if.sink    in,
  sri_out_if.source out
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  logic    back_ready;
  sri_op_t q_wr;
  sri_op_t q_rd;

  // Sample acceptance and classification.
  sri_front u_front (
    .clk  (clk),
    .rst  (rst),
    .in   (in),
    .push (q_push),
    .op   (q_wr),
    .full (q_full)
  );

  // Operation queue.
  sri_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  assign q_pop = !q_empty && back_ready;

  // Arithmetic back end and result register.
  sri_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op       (q_rd),
    .op_ready (back_ready),
    .out      (out)
  );

endmodule

`default_nettype wire

/* rtl/core/sri_front.sv */
// ----------------------------------------------------------------------------
// sri_front
// Accepts samples, keeps the two previous samples and the run phase, and
// turns each sample that completes a group or closes the run into a multiply operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sri_front
  import sri_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sri_in_if.sink    in,
  output logic      push,
  output sri_op_t   op,
  input  wire logic full
);

  // Run phase codes.
  localparam logic [1:0] PH_EMPTY = 2'd0;  // no samples yet
  localparam logic [1:0] PH_ONE   = 2'd1;  // exactly one sample
  localparam logic [1:0] PH_EVEN  = 2'd2;  // even count seen
  localparam logic [1:0] PH_ODD   = 2'd3;  // odd count of three or more

  logic signed [SRI_POS_W-1:0] older_pos;
  logic signed [SRI_VAL_W-1:0] older_val;
  logic signed [SRI_POS_W-1:0] prev_pos;
  logic signed [SRI_VAL_W-1:0] prev_val;
  logic [1:0]                  phase;
  logic [1:0]                  phase_next;

  logic                        accept;
  logic                        is_grp;
  logic                        is_trp;
  logic signed [SRI_DX_W-1:0]  grp_dx;
  logic signed [SRI_DX_W-1:0]  trp_dx;
  logic signed [SRI_WT_W-1:0]  grp_wt;
  logic signed [SRI_WT_W-1:0]  trp_wt;

  assign in.ready = !full;

  // Classify the sample and form the multiplier operands.
  always_comb begin
    accept = in.valid && in.ready;
    is_grp = (phase == PH_EVEN);
    is_trp = in.last && ((phase == PH_ONE) || (phase == PH_ODD));
    grp_dx = SRI_DX_W'(in.x_pos) - SRI_DX_W'(older_pos);
    trp_dx = SRI_DX_W'(in.x_pos) - SRI_DX_W'(prev_pos);
    grp_wt = SRI_WT_W'(older_val) + (SRI_WT_W'(prev_val) <<< 2) + SRI_WT_W'(in.sample);
    trp_wt = SRI_WT_W'(prev_val) + SRI_WT_W'(in.sample);
    op.grp = is_grp;
    op.trp = is_trp;
    op.lst = in.last;
    op.dx  = is_grp ? grp_dx : trp_dx;
    op.wt  = is_grp ? grp_wt : trp_wt;
    push   = accept && (is_grp || in.last);
  end

  // Phase advance for a sample that does not close the run.
  always_comb begin
    case (phase)
      PH_EMPTY: phase_next = PH_ONE;
      PH_EVEN:  phase_next = PH_ODD;
      default:  phase_next = PH_EVEN;
    endcase
  end

  // Sample history; the run state clears after the last sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      older_pos <= '0;
      older_val <= '0;
      prev_pos  <= '0;
      prev_val  <= '0;
      phase     <= PH_EMPTY;
    end else if (accept) begin
      if (in.last) begin
        older_pos <= '0;
        older_val <= '0;
        prev_pos  <= '0;
        prev_val  <= '0;
        phase     <= PH_EMPTY;
      end else begin
        older_pos <= prev_pos;
        older_val <= prev_val;
        prev_pos  <= in.x_pos;
        prev_val  <= in.sample;
        phase     <= phase_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sri_fifo.sv */
// ----------------------------------------------------------------------------
// sri_fifo
// Short queue of operations between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simpson_rule_integrator_macros.svh"

module sri_fifo
  import sri_pkg::*;
#(
  parameter int DEPTH = SRI_FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire sri_op_t wr_data,
  output logic         full,
  input  wire logic    pop,
  output sri_op_t      rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sri_op_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SRI_ASSERT_IMP(a_push_has_room, push, !full)
  `SRI_ASSERT_IMP(a_pop_has_entry, pop, !empty)

endmodule

`default_nettype wire

/* rtl/core/sri_back.sv */
// ----------------------------------------------------------------------------
// sri_back
// Multiplies, accumulates with saturation, divides the closed sum by six
// with rounding, adds the halved trapezoid and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simpson_rule_integrator_macros.svh"

module sri_back
  import sri_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    op_valid,
  input  wire sri_op_t op,
  output logic         op_ready,
  sri_out_if.source    out
);

  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS   = SRI_RES_W / DIV_STAGES;
  localparam int HALF_W     = SRI_PROD_W - 1;

  localparam logic signed [SRI_RES_W-1:0] RES_MAX = {1'b0, {(SRI_RES_W-1){1'b1}}};
  localparam logic signed [SRI_RES_W-1:0] RES_MIN = {1'b1, {(SRI_RES_W-1){1'b0}}};

  // One stage of the divide-by-three pipeline with the values riding along.
  typedef struct packed {
    logic                  neg;
    logic [1:0]            rem;
    logic [SRI_RES_W-1:0]  word;
    logic [HALF_W-1:0]     thalf;
    logic                  tneg;
    logic                  sat;
  } dstg_t;

  // Signed add clamped to the 64-bit range; the top bit flags a clamp.
  function automatic logic [SRI_RES_W:0] sat_add(input logic signed [SRI_RES_W-1:0] a,
                                                 input logic signed [SRI_RES_W-1:0] b);
    logic signed [SRI_RES_W-1:0] s;
    logic [SRI_RES_W:0]          r;
    s = a + b;
    if (!a[SRI_RES_W-1] && !b[SRI_RES_W-1] && s[SRI_RES_W-1]) begin
      r = {1'b1, RES_MAX};
    end else if (a[SRI_RES_W-1] && b[SRI_RES_W-1] && !s[SRI_RES_W-1]) begin
      r = {1'b1, RES_MIN};
    end else begin
      r = {1'b0, s};
    end
    return r;
  endfunction

  // Restoring long division by three, eight dividend bits per stage.
  function automatic dstg_t div_step(input dstg_t s);
    dstg_t      r;
    logic [2:0] t;
    r = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      t      = {r.rem, r.word[SRI_RES_W-1]};
      r.word = {r.word[SRI_RES_W-2:0], (t >= 3'd3)};
      r.rem  = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end
    return r;
  endfunction

  logic                          adv;

  // Multiply stage.
  logic                          m_vld;
  logic                          m_grp;
  logic                          m_trp;
  logic                          m_lst;
  logic signed [SRI_PROD_W-1:0]  m_prod;

  // Accumulator and its sum for this cycle.
  logic signed [SRI_RES_W-1:0]   acc;
  logic                          sat;
  logic [SRI_RES_W:0]            a_res;
  logic signed [SRI_RES_W-1:0]   a_sum;
  logic                          a_ovf;

  // Closed run waiting for rounding.
  logic                          d_vld;
  logic [SRI_RES_W-1:0]          d_acc;
  logic                          d_sat;
  logic                          d_trp;
  logic [SRI_PROD_W-1:0]         d_tprod;
  logic [SRI_RES_W-1:0]          d_mag;
  logic [SRI_PROD_W-1:0]         t_mag;
  dstg_t                         prep;

  // Division pipeline.
  logic [DIV_STAGES:0]           q_vld;
  dstg_t                         q_stg [DIV_STAGES+1];

  // Sign restore stage.
  logic                          n_vld;
  logic signed [SRI_RES_W-1:0]   n_total;
  logic signed [SRI_RES_W-1:0]   n_trap;
  logic                          n_sat;
  logic [SRI_RES_W:0]            o_res;

  // Output register.
  logic                          ov_valid;
  logic signed [SRI_RES_W-1:0]   ov_integral;
  logic                          ov_overflow;

  // The whole pipeline moves when the output register can take a result.
  assign adv          = !ov_valid || out.ready;
  assign op_ready     = adv;
  assign out.valid    = ov_valid;
  assign out.integral = ov_integral;
  assign out.overflow = ov_overflow;

  // Group term added to the running sum.
  always_comb begin
    a_res = sat_add(acc, SRI_RES_W'(m_prod));
    a_sum = m_grp ? a_res[SRI_RES_W-1:0] : acc;
    a_ovf = m_grp && a_res[SRI_RES_W];
  end

  // Magnitudes biased for round-half-away division by six and by two.
  always_comb begin
    d_mag = d_acc[SRI_RES_W-1] ? (~d_acc + SRI_RES_W'(4)) : (d_acc + SRI_RES_W'(3));
    t_mag = d_tprod[SRI_PROD_W-1] ? (~d_tprod + SRI_PROD_W'(2))
                                  : (d_tprod + SRI_PROD_W'(1));
    prep.neg   = d_acc[SRI_RES_W-1];
    prep.rem   = 2'd0;
    prep.word  = {1'b0, d_mag[SRI_RES_W-1:1]};
    prep.thalf = d_trp ? t_mag[SRI_PROD_W-1:1] : '0;
    prep.tneg  = d_trp && d_tprod[SRI_PROD_W-1];
    prep.sat   = d_sat;
  end

  assign o_res = sat_add(n_total, n_trap);

  // Control state: stage valids and the run accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld    <= 1'b0;
      acc      <= '0;
      sat      <= 1'b0;
      d_vld    <= 1'b0;
      q_vld    <= '0;
      n_vld    <= 1'b0;
      ov_valid <= 1'b0;
    end else if (adv) begin
      m_vld <= op_valid;
      if (m_vld && m_lst) begin
        acc <= '0;
        sat <= 1'b0;
      end else if (m_vld) begin
        acc <= a_sum;
        sat <= sat || a_ovf;
      end
      d_vld    <= m_vld && m_lst;
      q_vld    <= {q_vld[DIV_STAGES-1:0], d_vld};
      n_vld    <= q_vld[DIV_STAGES];
      ov_valid <= n_vld;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_grp   <= op.grp;
      m_trp   <= op.trp;
      m_lst   <= op.lst;
      m_prod  <= op.dx * op.wt;
      d_acc   <= a_sum;
      d_sat   <= sat || a_ovf;
      d_trp   <= m_trp;
      d_tprod <= m_prod;
      q_stg[0] <= prep;
      for (int k = 0; k < DIV_STAGES; k++) begin
        q_stg[k+1] <= div_step(q_stg[k]);
      end
      n_total <= q_stg[DIV_STAGES].neg ? (SRI_RES_W'(0) - q_stg[DIV_STAGES].word)
                                       : q_stg[DIV_STAGES].word;
      n_trap  <= q_stg[DIV_STAGES].tneg ? (SRI_RES_W'(0) - SRI_RES_W'(q_stg[DIV_STAGES].thalf))
                                        : SRI_RES_W'(q_stg[DIV_STAGES].thalf);
      n_sat   <= q_stg[DIV_STAGES].sat;
      ov_integral <= o_res[SRI_RES_W-1:0];
      ov_overflow <= n_sat || o_res[SRI_RES_W];
    end
  end

  `SRI_ASSERT_NXT(a_stall_holds_acc, ov_valid && !out.ready, $stable(acc))
  `SRI_ASSERT_NXT(a_close_clears_acc, adv && m_vld && m_lst, (acc == '0) && !sat)

endmodule

`default_nettype wire
